// ----- sv/cn0b_pkg.sv -----
// shared constants, types and the log table function of the c/n0 estimator
package cn0b_pkg;

	localparam int LOG_TABLE_BITS_DEF = 6;

	localparam logic [47:0] NSR_CAP     = 48'd268435456000000;
	localparam logic [47:0] NSR_RESET   = 48'd268435456;
	localparam logic [16:0] ONE_Q16     = 17'd65536;
	localparam logic [16:0] ALPHA_RESET = 17'd6554;
	localparam logic [19:0] MILLION     = 20'd1000000;
	localparam logic [17:0] TEN_LOG10_2 = 18'd197283;
	localparam logic [14:0] DB_MAX      = 15'd25600;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 48;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_NORM_BW     = 3'd0,
		REG_AVG_COEFF   = 3'd1,
		REG_INITIAL_NSR = 3'd2,
		REG_USE_QUAD    = 3'd3
	} cfg_reg_t;

	// one classified item handed from front to back
	typedef struct packed {
		logic [31:0] twopn;
		logic [31:0] ps2;
		logic        primed;
	} cn0b_item_t;

	// log2(1 + k/2^bits) in q16, square-and-compare, truncated
	function automatic logic [16:0] log_entry(input int k, input int bits);
		logic [63:0] m;
		logic [15:0] r;
		int          b;
		m = 64'd0;
		r = 16'd0;
		if (k >= (1 << bits)) begin
			return ONE_Q16;
		end
		m = (64'd1 << 30) + ((64'(k) << 30) >> bits);
		for (b = 0; b < 16; b++) begin
			m = (m * m) >> 30;
			r = {r[14:0], 1'b0};
			if (m >= (64'd2 << 30)) begin
				r[0] = 1'b1;
				m = m >> 1;
			end
		end
		return {1'b0, r};
	endfunction

endpackage

// ----- sv/cn0b_front.sv -----
// front part: magnitudes, noise and signal power terms, first-sample flag
module cn0b_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [15:0]   in_phase,
	input  logic signed [15:0]   quadrature,
	input  logic                 use_quad,
	input  logic                 full,
	output logic                 push,
	output cn0b_pkg::cn0b_item_t push_item
);
	import cn0b_pkg::*;

	logic [15:0] iv, qv, ia, qa, cur, old, d;
	logic [15:0] prev_i_q, prev_q_q;
	logic        have_prev_q;
	logic [31:0] pn, sq_cur, sq_old;

	assign in_stall = full;
	assign push     = in_valid & ~full;

	assign iv  = in_phase;
	assign qv  = quadrature;
	assign ia  = iv[15] ? (~iv + 16'd1) : iv;
	assign qa  = qv[15] ? (~qv + 16'd1) : qv;
	assign cur = use_quad ? qa : ia;
	assign old = use_quad ? prev_q_q : prev_i_q;
	assign d   = (cur > old) ? (cur - old) : (old - cur);

	assign pn     = d * d;
	assign sq_cur = ia * ia;
	assign sq_old = prev_i_q * prev_i_q;

	// pn is at most 2^30, so doubling fits 32 bits
	assign push_item.twopn  = {pn[30:0], 1'b0};
	assign push_item.ps2    = sq_cur + sq_old;
	assign push_item.primed = have_prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_i_q    <= '0;
			prev_q_q    <= '0;
			have_prev_q <= 1'b0;
		end else if (push) begin
			prev_i_q    <= ia;
			prev_q_q    <= qa;
			have_prev_q <= 1'b1;
		end
	end

endmodule

// ----- sv/cn0b_fifo.sv -----
// two-entry item queue between front and back
module cn0b_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cn0b_pkg::cn0b_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 pop_valid,
	output cn0b_pkg::cn0b_item_t pop_item
);
	import cn0b_pkg::*;

	cn0b_item_t  mem_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;

	assign full      = (count_q == 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- sv/cn0b_back.sv -----
// back part: serial divide, iir average, normalize, log table and db result
module cn0b_back #(
	parameter int LOG_TABLE_BITS = cn0b_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop,
	input  cn0b_pkg::cn0b_item_t pop_item,
	input  logic [15:0]          norm_bw,
	input  logic [16:0]          avg_coeff,
	input  logic                 load_avg,
	input  logic [47:0]          load_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [14:0]          cn0_db,
	output logic                 primed
);
	import cn0b_pkg::*;

	localparam int TAB_LEN = (1 << LOG_TABLE_BITS) + 1;
	localparam int TAB_IW  = LOG_TABLE_BITS + 1;
	localparam int T_HI    = 46 - LOG_TABLE_BITS;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b000_0000_0001,
		S_CAP    = 11'b000_0000_0010,
		S_SETUP  = 11'b000_0000_0100,
		S_DIV    = 11'b000_0000_1000,
		S_MACSET = 11'b000_0001_0000,
		S_MAC    = 11'b000_0010_0000,
		S_NORM   = 11'b000_0100_0000,
		S_LOG1   = 11'b000_1000_0000,
		S_LOG2   = 11'b001_0000_0000,
		S_LOG3   = 11'b010_0000_0000,
		S_DONE   = 11'b100_0000_0000
	} state_t;

	logic [16:0] tab [TAB_LEN];

	for (genvar gk = 0; gk < TAB_LEN; gk++) begin : g_tab
		assign tab[gk] = log_entry(gk, LOG_TABLE_BITS);
	end

	state_t             st_q;
	logic [31:0]        twopn_q, ps2_q, rem_q;
	logic               item_primed_q;
	logic [51:0]        capprod_q;
	logic [47:0]        num_q, quot_q, avg_q, x_q, nsr;
	logic [5:0]         cnt_q, e_q;
	logic signed [66:0] acc_q, dsh_q, acc_nx;
	logic [16:0]        alpha_q, tk_q;
	logic [32:0]        ip_q;
	logic signed [42:0] p_q;
	logic [14:0]        cres_q, cn0_q;
	logic               out_valid_q, primed_out_q;

	// divider step
	logic [32:0] shifted;
	logic        ge;
	assign shifted = {rem_q, num_q[47]};
	assign ge      = shifted >= {1'b0, ps2_q};

	// average step
	logic [50:0] avg_full;
	logic [47:0] avg_nx;
	assign acc_nx   = alpha_q[0] ? (acc_q + dsh_q) : acc_q;
	assign avg_full = acc_nx[66:16];
	assign avg_nx   = (avg_full > 51'(NSR_CAP)) ? NSR_CAP : avg_full[47:0];
	assign nsr      = (quot_q > NSR_CAP) ? NSR_CAP : quot_q;

	// table lookup, fraction bits start just below the leading one at bit 47
	logic [LOG_TABLE_BITS-1:0] k;
	logic [15:0]               t;
	logic [16:0]               tab_lo, tab_hi;
	assign k      = x_q[46 -: LOG_TABLE_BITS];
	assign t      = x_q[T_HI -: 16];
	assign tab_lo = tab[{1'b0, k}];
	assign tab_hi = tab[TAB_IW'({1'b0, k}) + TAB_IW'(1)];

	// log2 and db
	logic [17:0]        lf;
	logic signed [6:0]  ediff;
	logic signed [23:0] l2;
	logic [44:0]        p2;
	logic signed [18:0] db;
	logic signed [20:0] cval;
	assign lf    = {1'b0, tk_q} + {1'b0, ip_q[32:16]};
	assign ediff = $signed({1'b0, e_q}) - 7'sd28;
	assign l2    = $signed({ediff[6], ediff, 16'd0}) + $signed({6'd0, lf});
	assign p2    = 45'($signed(p_q)) + (45'd1 << 40) + (45'd1 << 23);
	assign db    = $signed({1'b0, p2[41:24]}) - 19'sd65536;
	assign cval  = $signed({{5{norm_bw[15]}}, norm_bw}) - 21'(db);

	assign pop       = (st_q == S_IDLE) && pop_valid;
	assign out_valid = out_valid_q;
	assign cn0_db    = cn0_q;
	assign primed    = primed_out_q;

	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: begin
				twopn_q       <= pop_item.twopn;
				ps2_q         <= pop_item.ps2;
				item_primed_q <= pop_item.primed;
				x_q           <= avg_q;
				e_q           <= 6'd47;
			end
			S_CAP: begin
				capprod_q <= ps2_q * MILLION;
			end
			S_SETUP: begin
				if ((capprod_q < 52'(twopn_q)) || (ps2_q == 32'd0)) begin
					quot_q <= NSR_CAP;
				end else begin
					quot_q <= '0;
				end
				rem_q <= 32'(twopn_q[31:20]);
				num_q <= {twopn_q[19:0], 28'd0};
				cnt_q <= 6'd47;
			end
			S_DIV: begin
				rem_q  <= ge ? 32'(shifted - {1'b0, ps2_q}) : shifted[31:0];
				num_q  <= {num_q[46:0], 1'b0};
				quot_q <= {quot_q[46:0], ge};
				cnt_q  <= cnt_q - 6'd1;
			end
			S_MACSET: begin
				acc_q   <= $signed({3'd0, avg_q, 16'd0}) + 67'sd32768;
				dsh_q   <= $signed({19'd0, nsr}) - $signed({19'd0, avg_q});
				alpha_q <= (avg_coeff > ONE_Q16) ? ONE_Q16 : avg_coeff;
				cnt_q   <= 6'd16;
			end
			S_MAC: begin
				acc_q   <= acc_nx;
				dsh_q   <= dsh_q <<< 1;
				alpha_q <= alpha_q >> 1;
				cnt_q   <= cnt_q - 6'd1;
				x_q     <= avg_nx;
				e_q     <= 6'd47;
			end
			S_NORM: begin
				if (x_q == 48'd0) begin
					cres_q <= DB_MAX;
				end else if (!x_q[47]) begin
					if (x_q[47:40] == 8'd0) begin
						x_q <= x_q << 8;
						e_q <= e_q - 6'd8;
					end else begin
						x_q <= x_q << 1;
						e_q <= e_q - 6'd1;
					end
				end
			end
			S_LOG1: begin
				tk_q <= tab_lo;
				ip_q <= (tab_hi - tab_lo) * t;
			end
			S_LOG2: begin
				p_q <= l2 * $signed({1'b0, TEN_LOG10_2});
			end
			S_LOG3: begin
				if (cval < 21'sd0) begin
					cres_q <= '0;
				end else if (cval > $signed({6'd0, DB_MAX})) begin
					cres_q <= DB_MAX;
				end else begin
					cres_q <= cval[14:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			avg_q        <= NSR_RESET;
			out_valid_q  <= 1'b0;
			cn0_q        <= '0;
			primed_out_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (load_avg) begin
				avg_q <= (load_value > NSR_CAP) ? NSR_CAP : load_value;
			end
			case (st_q)
				S_IDLE: begin
					if (pop_valid) begin
						st_q <= pop_item.primed ? S_CAP : S_NORM;
					end
				end
				S_CAP:    st_q <= S_SETUP;
				S_SETUP: begin
					if ((capprod_q < 52'(twopn_q)) || (ps2_q == 32'd0)) begin
						st_q <= S_MACSET;
					end else begin
						st_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (cnt_q == 6'd0) begin
						st_q <= S_MACSET;
					end
				end
				S_MACSET: st_q <= S_MAC;
				S_MAC: begin
					if (cnt_q == 6'd0) begin
						avg_q <= avg_nx;
						st_q  <= S_NORM;
					end
				end
				S_NORM: begin
					if (x_q == 48'd0) begin
						st_q <= S_DONE;
					end else if (x_q[47]) begin
						st_q <= S_LOG1;
					end
				end
				S_LOG1:   st_q <= S_LOG2;
				S_LOG2:   st_q <= S_LOG3;
				S_LOG3:   st_q <= S_DONE;
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						cn0_q        <= cres_q;
						primed_out_q <= item_primed_q;
						out_valid_q  <= 1'b1;
						st_q         <= S_IDLE;
					end
				end
				default:  st_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/cn0_estimator_beaulieu_top.sv -----
// top level of the beaulieu c/n0 estimator: config registers, front, queue, back
// path from input accept to result valid: queue, 48-step divider, 17-step average,
// up to 13 normalize steps, 3 log steps; the first item after reset skips divider and
// average, a capped nsr skips the divider, a zero average skips the log
// back part takes an item only when idle, a stalled result holds it; the queue holds two
// reset: asynchronous, active low; registers go to their defaults, average nsr to 1.0
module cn0_estimator_beaulieu_top #(
	parameter int LOG_TABLE_BITS = cn0b_pkg::LOG_TABLE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input item channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [15:0]                 in_phase,
	input  logic signed [15:0]                 quadrature,
	// result item channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [14:0]                        cn0_db,
	output logic                               primed,
	// config write port
	input  logic                               cfg_we,
	input  logic [cn0b_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [cn0b_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import cn0b_pkg::*;

	// config registers
	logic [15:0] norm_bw_q;
	logic [16:0] avg_coeff_q;
	logic        use_quad_q;
	logic        load_avg;

	// an initial nsr write reloads the running average in the back part
	assign load_avg = cfg_we && (cfg_index == REG_INITIAL_NSR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			norm_bw_q   <= '0;
			avg_coeff_q <= ALPHA_RESET;
			use_quad_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NORM_BW:   norm_bw_q   <= cfg_data[15:0];
				REG_AVG_COEFF: avg_coeff_q <= cfg_data[16:0];
				REG_USE_QUAD:  use_quad_q  <= cfg_data[0];
				default: begin
					// initial nsr handled by load_avg, unknown indexes ignored
				end
			endcase
		end
	end

	// front to queue
	logic       push, full, pop, pop_valid;
	cn0b_item_t push_item, pop_item;

	cn0b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_phase   (in_phase),
		.quadrature (quadrature),
		.use_quad   (use_quad_q),
		.full       (full),
		.push       (push),
		.push_item  (push_item)
	);

	// short queue lets the front keep taking items while the back works
	cn0b_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	// back part holds the running average and the output register
	cn0b_back #(
		.LOG_TABLE_BITS (LOG_TABLE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_item   (pop_item),
		.norm_bw    (norm_bw_q),
		.avg_coeff  (avg_coeff_q),
		.load_avg   (load_avg),
		.load_value (cfg_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cn0_db     (cn0_db),
		.primed     (primed)
	);

endmodule

// ----- sv/cn0b_checker.sv -----
// port-level checker of the c/n0 estimator and its bind
module cn0b_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic signed [15:0]               in_phase,
	input logic signed [15:0]               quadrature,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic [14:0]                      cn0_db,
	input logic                             primed,
	input logic                             cfg_we,
	input logic [cn0b_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [cn0b_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import cn0b_pkg::*;

	logic       in_acc, out_acc;
	logic [2:0] pending_q;
	logic       delivered_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= '0;
			delivered_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
			if (out_acc) begin
				delivered_q <= 1'b1;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cn0_db) && $stable(primed))
		else $error("stalled result changed");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cn0_db <= DB_MAX)
		else $error("cn0 out of range");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result without an accepted item");

	a_primed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && delivered_q |-> primed)
		else $error("unprimed result after the first");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd4)
		else $error("too many items in flight");

endmodule

bind cn0_estimator_beaulieu_top cn0b_checker u_cn0b_checker (.*);

// ----- tb/sv/cn0_estimator_beaulieu_top_tb.sv -----
// self-checking testbench of the beaulieu c/n0 estimator top level
module cn0_estimator_beaulieu_top_tb;
	import cn0b_pkg::*;

	localparam int TAB_BITS = LOG_TABLE_BITS_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 200;
	// index that maps to no register, writes to it must be ignored
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd6;

	typedef struct {
		logic signed [15:0] i_val;
		logic signed [15:0] q_val;
		bit                 typed;
		logic [14:0]        cn0;
		logic               primed;
	} stim_row_t;

	typedef struct {
		logic [14:0] cn0;
		logic        primed;
	} cn0_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic signed [15:0]     in_phase = '0;
	logic signed [15:0]     quadrature = '0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic [14:0]            cn0_db;
	logic                   primed;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	cn0_estimator_beaulieu_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_phase(in_phase), .quadrature(quadrature),
		.out_valid(out_valid), .out_stall(out_stall), .cn0_db(cn0_db), .primed(primed),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// mirror of the block's registers and state
	logic signed [15:0] bw_db;
	logic [16:0]        alpha;
	logic               quad_mode;
	logic [15:0]        last_i_mag;
	logic [15:0]        last_q_mag;
	logic               seen_first;
	logic [47:0]        nsr_avg;
	logic [16:0]        log2_tab [0:(1 << TAB_BITS)];

	cn0_result_t cn0_pending [$];
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          settings_used = 0;
	int          cycles = 0;
	bit          quiet = 1'b0;

	// log2(1 + k/2^bits) in q16 by repeated squaring
	function automatic void fill_log2_tab();
		logic [63:0] m;
		logic [15:0] r;
		for (int k = 0; k < (1 << TAB_BITS); k++) begin
			m = (64'd1 << 30) + ((64'(k) << 30) >> TAB_BITS);
			r = '0;
			for (int b = 0; b < 16; b++) begin
				m = (m * m) >> 30;
				r = r << 1;
				if (m >= (64'd2 << 30)) begin
					r[0] = 1'b1;
					m = m >> 1;
				end
			end
			log2_tab[k] = {1'b0, r};
		end
		log2_tab[1 << TAB_BITS] = ONE_Q16;
	endfunction

	function automatic logic [47:0] cap_nsr(input logic [79:0] v);
		return (v > 80'(NSR_CAP)) ? NSR_CAP : v[47:0];
	endfunction

	// bandwidth minus 10*log10 of the averaged nsr, clamped to 0..100 db
	function automatic logic [14:0] cn0_from_avg();
		int          e;
		logic [63:0] frac;
		int          k;
		longint      t, lf, l2, p, db, c;
		if (nsr_avg == 0)
			return DB_MAX;
		e = 47;
		while (e > 0 && !nsr_avg[e])
			e--;
		frac = ({16'd0, nsr_avg} << (63 - e)) << 1;
		k = int'(frac >> (64 - TAB_BITS));
		t = longint'((frac >> (64 - TAB_BITS - 16)) & 64'hFFFF);
		lf = longint'(log2_tab[k])
			+ (((longint'(log2_tab[k + 1]) - longint'(log2_tab[k])) * t) >>> 16);
		l2 = longint'(e - 28) * 65536 + lf;
		p = l2 * longint'(TEN_LOG10_2) + (64'sd1 <<< 40) + (64'sd1 <<< 23);
		db = (p >>> 24) - 65536;
		c = longint'(bw_db) - db;
		if (c < 0)
			c = 0;
		if (c > longint'(DB_MAX))
			c = longint'(DB_MAX);
		return c[14:0];
	endfunction

	function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		case (cfg_reg_t'(idx))
			REG_NORM_BW: bw_db = val[15:0];
			REG_AVG_COEFF: alpha = val[16:0];
			REG_INITIAL_NSR: nsr_avg = cap_nsr(80'(val));
			REG_USE_QUAD: quad_mode = val[0];
			default: ;
		endcase
	endfunction

	// one correlator pair through the estimator
	function automatic cn0_result_t estimate_cn0(input logic [15:0] iv, input logic [15:0] qv);
		logic [15:0] ia, qa, cur, old;
		logic [63:0] d, pn, ps2, nsr;
		logic [16:0] a;
		logic [79:0] mix;
		cn0_result_t r;
		ia = iv[15] ? 16'(17'h10000 - iv) : iv;
		qa = qv[15] ? 16'(17'h10000 - qv) : qv;
		r.primed = seen_first;
		if (seen_first) begin
			cur = quad_mode ? qa : ia;
			old = quad_mode ? last_q_mag : last_i_mag;
			d = (cur > old) ? 64'(cur - old) : 64'(old - cur);
			pn = d * d;
			ps2 = 64'(ia) * ia + 64'(last_i_mag) * last_i_mag;
			if (ps2 * 64'd1000000 < 2 * pn || ps2 == 0)
				nsr = 64'(NSR_CAP);
			else
				nsr = 64'(cap_nsr(80'(((2 * pn) << 28) / ps2)));
			a = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
			mix = 80'(nsr_avg) * (ONE_Q16 - a) + 80'(nsr) * a + 80'd32768;
			nsr_avg = cap_nsr(mix >> 16);
		end
		last_i_mag = ia;
		last_q_mag = qa;
		seen_first = 1'b1;
		r.cn0 = cn0_from_avg();
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, val);
	endtask

	// registers are only touched with nothing in flight
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (cn0_pending.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic load_setting(input logic [15:0] bw, input logic [16:0] a,
			input logic [47:0] init, input logic quad);
		wait_drained();
		write_reg(REG_NORM_BW, 48'(bw));
		write_reg(REG_AVG_COEFF, 48'(a));
		write_reg(REG_INITIAL_NSR, init);
		write_reg(REG_USE_QUAD, 48'(quad));
		settings_used++;
	endtask

	// offer one item, hold it until taken, then queue what it should produce
	task automatic send_pair(input stim_row_t row, input int idle_pct);
		cn0_result_t r;
		in_valid <= 1'b1;
		in_phase <= row.i_val;
		quadrature <= row.q_val;
		do
			@(posedge clk);
		while (in_stall);
		r = estimate_cn0(row.i_val, row.q_val);
		if (row.typed) begin
			r.cn0 = row.cn0;
			r.primed = row.primed;
		end
		cn0_pending.push_back(r);
		items_sent++;
		if (!quiet && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	// mostly a steady carrier with small noise, some full-range and corner values
	function automatic stim_row_t pick_pair(input int amp, input int noise);
		stim_row_t row;
		int mode;
		int m;
		row.typed = 1'b0;
		row.cn0 = '0;
		row.primed = 1'b0;
		mode = $urandom_range(0, 9);
		if (mode < 2) begin
			row.i_val = 16'($urandom);
			row.q_val = 16'($urandom);
		end else if (mode == 2) begin
			row.i_val = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			row.q_val = $urandom_range(0, 2) == 0 ? 16'sh0000 : 16'(-$urandom_range(0, 1));
		end else begin
			m = amp + $urandom_range(0, noise) - noise / 2;
			if (m > 32767)
				m = 32767;
			if (m < 0)
				m = 0;
			row.i_val = $urandom_range(0, 7) == 0 ? 16'(-m) : 16'(m);
			row.q_val = 16'($urandom_range(0, noise) - noise / 2);
		end
		return row;
	endfunction

	// result side: random stall bursts, one long hold to back the block up
	int stall_left = 0;
	int hold_left = 0;
	bit held = 1'b0;
	always @(posedge clk) begin
		cn0_result_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (cn0_pending.size() == 0) begin
				$error("result with no item pending: cn0_db=%0d primed=%0d", cn0_db, primed);
				errors++;
			end else begin
				want = cn0_pending.pop_front();
				if (cn0_db !== want.cn0) begin
					$error("cn0_db: expected %0d, got %0d", want.cn0, cn0_db);
					errors++;
				end
				if (primed !== want.primed) begin
					$error("primed: expected %0d, got %0d", want.primed, primed);
					errors++;
				end
			end
		end
		// long hold after the first few dozen results
		if (results_seen == 60 && !held) begin
			held = 1'b1;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			stall_left = $urandom_range(1, 9) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	stim_row_t corner_rows [0:13];

	initial begin
		int amp;
		int noise;
		int idle_pct;
		logic [15:0] bw;
		logic [16:0] a;
		logic [47:0] init;
		fill_log2_tab();
		bw_db = '0;
		alpha = ALPHA_RESET;
		quad_mode = 1'b0;
		last_i_mag = '0;
		last_q_mag = '0;
		seen_first = 1'b0;
		nsr_avg = NSR_RESET;

		// first item after reset only primes, bw 0 and nsr 1.0 give 0 db;
		// consecutive zero pairs hit the capped nsr
		corner_rows[0] = '{16'sh0000, 16'sh0000, 1'b1, 15'd0, 1'b0};
		corner_rows[1] = '{16'sh0000, 16'sh0000, 1'b0, 15'd0, 1'b0};
		corner_rows[2] = '{16'sh7FFF, 16'sh8000, 1'b0, 15'd0, 1'b0};
		corner_rows[3] = '{16'sh8000, 16'sh7FFF, 1'b0, 15'd0, 1'b0};
		corner_rows[4] = '{16'sh0001, 16'shFFFF, 1'b0, 15'd0, 1'b0};
		corner_rows[5] = '{16'shFFFF, 16'sh0001, 1'b0, 15'd0, 1'b0};
		corner_rows[6] = '{16'sh7FFF, 16'sh7FFF, 1'b0, 15'd0, 1'b0};
		corner_rows[7] = '{16'sh8000, 16'sh8000, 1'b0, 15'd0, 1'b0};
		corner_rows[8] = '{16'sh0064, 16'shFF9C, 1'b0, 15'd0, 1'b0};
		corner_rows[9] = '{16'sh0065, 16'sh0063, 1'b0, 15'd0, 1'b0};
		// zero average with alpha zero stays at the top of the scale
		corner_rows[10] = '{16'sh01F4, 16'sh0003, 1'b1, DB_MAX, 1'b1};
		corner_rows[11] = '{16'sh8000, 16'sh0000, 1'b1, DB_MAX, 1'b1};
		corner_rows[12] = '{16'sh0000, 16'sh7FFF, 1'b1, DB_MAX, 1'b1};
		corner_rows[13] = '{16'sh0000, 16'sh0000, 1'b1, DB_MAX, 1'b1};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 10; r++)
			send_pair(corner_rows[r], 30);
		load_setting(16'h8000, 17'd0, 48'd0, 1'b0);
		for (int r = 10; r < 14; r++)
			send_pair(corner_rows[r], 30);

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin bw = 16'h7FFF; a = ONE_Q16; init = NSR_CAP; end
				1: begin bw = 16'h8000; a = 17'h1FFFF; init = 48'hFFFF_FFFF_FFFF; end
				2: begin
					bw = 16'h2800;
					a = 17'd0;
					init = 48'({$urandom, $urandom} >> $urandom_range(0, 40));
				end
				default: begin
					bw = 16'($urandom_range(16'h1000, 16'h7000));
					a = $urandom_range(0, 3) == 0 ? 17'($urandom) : 17'($urandom_range(1, 65536));
					init = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
				end
			endcase
			load_setting(bw, a, init, ph[0] ^ ph[2]);
			// unknown index must leave every register alone
			if (ph == 1)
				write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
			amp = $urandom_range(500, 30000);
			noise = $urandom_range(2, 2000);
			idle_pct = (ph == 3) ? 0 : 35;
			quiet = (ph == 5);
			for (int n = 0; n < 70; n++) begin
				// sender stops until everything in flight has come back
				if (ph == 1 && n == 35) begin
					in_valid <= 1'b0;
					while (cn0_pending.size() != 0)
						@(posedge clk);
				end
				send_pair(pick_pair(amp, noise), idle_pct);
			end
		end
		in_valid <= 1'b0;

		while (cn0_pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d items over %0d register settings, %0d results checked, %0d failures",
			items_sent, settings_used, results_seen, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
